// ===== src/shlp_pkg.sv =====
// Shared constants, field codes and control structs for the storage header parser.
// No dependencies; tb imports it; src, except shlp_chunk_check, uses scoped names.
`default_nettype none

package shlp_pkg;

  // Fixed widths of the beat payloads
  localparam int BYTE_W       = 8;
  localparam int REV_W        = 20;
  localparam int BYTES_OUT_W  = 20;
  localparam int CHUNKS_OUT_W = 9;
  localparam int HASH_W       = 64;
  localparam int FIELD_IDX_W  = 3;

  // Default values of the top-level parameters
  localparam logic [63:0] CHUNK_SIZE_DEF    = 64'd4096;
  localparam logic [63:0] WIRE_CAPACITY_DEF = 64'd1048576;
  localparam logic [63:0] MAX_REVISION_DEF  = 64'd1048575;

  // Header field order; FLD_DONE follows the fifth newline
  localparam logic [FIELD_IDX_W-1:0] FLD_SCHEMA   = 3'd0;
  localparam logic [FIELD_IDX_W-1:0] FLD_REVISION = 3'd1;
  localparam logic [FIELD_IDX_W-1:0] FLD_BYTES    = 3'd2;
  localparam logic [FIELD_IDX_W-1:0] FLD_CHUNKS   = 3'd3;
  localparam logic [FIELD_IDX_W-1:0] FLD_HASH     = 3'd4;
  localparam logic [FIELD_IDX_W-1:0] FLD_DONE     = 3'd5;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0a;

  // Only schema version accepted
  localparam logic [63:0] SCHEMA_VALUE = 64'd1;

  // Digit counter saturation point
  localparam logic [1:0] DCNT_SAT = 2'd2;

  // Control into the field scanner
  typedef struct packed {
    logic go;    // stage byte is consumed this cycle
    logic last;  // stage byte carries the final flag
  } scan_ctl_t;

  // Status out of the field scanner, valid for the byte being consumed
  typedef struct packed {
    logic complete;  // fifth newline seen and no error latched
  } scan_sts_t;

endpackage

`default_nettype wire

// ===== src/shlp_if.sv =====
// Valid/ready channel interfaces for header byte beats and parse result beats.
// Depends on shlp_pkg for payload widths.
`default_nettype none

interface shlp_in_if;
  logic                             valid;
  logic                             ready;
  logic [shlp_pkg::BYTE_W-1:0]      text_byte;
  logic                             final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface shlp_out_if;
  logic                               valid;
  logic                               ready;
  logic                               status;
  logic [shlp_pkg::REV_W-1:0]         revision;
  logic [shlp_pkg::BYTES_OUT_W-1:0]   byte_count;
  logic [shlp_pkg::CHUNKS_OUT_W-1:0]  chunk_count;
  logic [shlp_pkg::HASH_W-1:0]        content_hash;

  modport source (output valid, output status, output revision, output byte_count,
                  output chunk_count, output content_hash, input ready);
  modport sink   (input valid, input status, input revision, input byte_count,
                  input chunk_count, input content_hash, output ready);
endinterface

`default_nettype wire

// ===== src/storage_header_line_parser.sv =====
// Top level of the storage header parser: input stage, scanner, chunk check, result register.
// Depends on shlp_pkg, shlp_if, shlp_field_scan and shlp_chunk_check.
`default_nettype none

// The parser takes one header character per beat, one beat per clock cycle
// sustained unless a final byte waits behind an untaken result, and answers each
// beat that carries final_byte with a single result beat; other beats give no
// result. A byte waits in the input stage, where the decimal step (accumulator
// times ten plus digit, compared against the field bound) runs. The result register
// loads on the same edge at which the final byte leaves that stage, and offers the
// result beat from then on. in_chan.ready falls only while a final byte waits in
// the stage behind a result that has not been taken. A parse error gives status 1
// with all numeric fields zero; the parser is back at the start of a header on
// the beat after the final byte.
module storage_header_line_parser #(
  parameter logic [63:0] CHUNK_SIZE    = shlp_pkg::CHUNK_SIZE_DEF,
  parameter logic [63:0] WIRE_CAPACITY = shlp_pkg::WIRE_CAPACITY_DEF,
  parameter logic [63:0] MAX_REVISION  = shlp_pkg::MAX_REVISION_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  shlp_in_if.sink     in_chan,
  shlp_out_if.source  out_chan
);

  localparam logic [63:0] BYTES_MAX  = WIRE_CAPACITY - 64'd1;
  localparam logic [63:0] CHUNKS_MAX = WIRE_CAPACITY / CHUNK_SIZE + 64'd1;
  localparam int          BYTES_W    = $clog2(WIRE_CAPACITY);
  localparam int          CHUNKS_W   = $clog2(CHUNKS_MAX + 64'd1);

  // Input stage
  logic                          stg_vld_r, stg_vld_nxt;
  logic [shlp_pkg::BYTE_W-1:0]   stg_byte_r;
  logic                          stg_final_r;
  logic                          go;
  logic                          in_ready;

  // Result register
  logic                              out_vld_r, out_vld_nxt;
  logic                              status_r;
  logic [shlp_pkg::REV_W-1:0]        rev_out_r;
  logic [shlp_pkg::BYTES_OUT_W-1:0]  bytes_out_r;
  logic [shlp_pkg::CHUNKS_OUT_W-1:0] chunks_out_r;
  logic [shlp_pkg::HASH_W-1:0]       hash_out_r;
  logic                              load;
  logic                              ok;

  shlp_pkg::scan_ctl_t           scan_ctl;
  shlp_pkg::scan_sts_t           scan_sts;
  logic [shlp_pkg::REV_W-1:0]    scan_rev;
  logic [BYTES_W-1:0]            scan_bytes;
  logic [CHUNKS_W-1:0]           scan_chunks;
  logic [shlp_pkg::HASH_W-1:0]   scan_hash;
  logic                          chunk_ok;

  // Advance the stage unless a final byte would overwrite an untaken result
  assign go       = stg_vld_r && (!stg_final_r || !out_vld_r || out_chan.ready);
  assign in_ready = !stg_vld_r || go;
  assign load     = go && stg_final_r;

  assign stg_vld_nxt = (in_chan.valid && in_ready) ? 1'b1 : (go ? 1'b0 : stg_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
    end
  end

  // Capture the byte beat
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_ready) begin
      stg_byte_r  <= in_chan.text_byte;
      stg_final_r <= in_chan.final_byte;
    end
  end

  assign scan_ctl.go   = go;
  assign scan_ctl.last = stg_final_r;

  shlp_field_scan #(
    .MAX_REVISION (MAX_REVISION),
    .BYTES_MAX    (BYTES_MAX),
    .CHUNKS_MAX   (CHUNKS_MAX),
    .BYTES_W      (BYTES_W),
    .CHUNKS_W     (CHUNKS_W)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .text_byte (stg_byte_r),
    .sts       (scan_sts),
    .revision  (scan_rev),
    .bytes     (scan_bytes),
    .chunks    (scan_chunks),
    .hash_upd  (scan_hash)
  );

  shlp_chunk_check #(
    .CHUNK_SIZE (CHUNK_SIZE),
    .BYTES_W    (BYTES_W),
    .CHUNKS_W   (CHUNKS_W)
  ) u_chunk (
    .clk      (clk),
    .bytes    (scan_bytes),
    .chunks   (scan_chunks),
    .chunk_ok (chunk_ok)
  );

  assign ok = scan_sts.complete && chunk_ok;

  // Hold the result until taken; load a new one on the final byte
  assign out_vld_nxt = load ? 1'b1 : (out_chan.ready ? 1'b0 : out_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r     <= !ok;
      rev_out_r    <= ok ? scan_rev : '0;
      bytes_out_r  <= ok ? shlp_pkg::BYTES_OUT_W'(scan_bytes) : '0;
      chunks_out_r <= ok ? shlp_pkg::CHUNKS_OUT_W'(scan_chunks) : '0;
      hash_out_r   <= ok ? scan_hash : '0;
    end
  end

  assign in_chan.ready         = in_ready;
  assign out_chan.valid        = out_vld_r;
  assign out_chan.status       = status_r;
  assign out_chan.revision     = rev_out_r;
  assign out_chan.byte_count   = bytes_out_r;
  assign out_chan.chunk_count  = chunks_out_r;
  assign out_chan.content_hash = hash_out_r;

endmodule

`default_nettype wire

// ===== src/shlp_field_scan.sv =====
// Field scanner: decimal accumulation, per-digit bound test and error latch.
// Depends on shlp_pkg for field codes, character codes and control structs.
`default_nettype none

module shlp_field_scan #(
  parameter logic [63:0] MAX_REVISION = shlp_pkg::MAX_REVISION_DEF,
  parameter logic [63:0] BYTES_MAX    = shlp_pkg::WIRE_CAPACITY_DEF - 64'd1,
  parameter logic [63:0] CHUNKS_MAX   = 64'd257,
  parameter int          BYTES_W      = 20,
  parameter int          CHUNKS_W     = 9
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire shlp_pkg::scan_ctl_t            ctl,
  input  wire logic [shlp_pkg::BYTE_W-1:0]    text_byte,
  output shlp_pkg::scan_sts_t                 sts,
  output logic [shlp_pkg::REV_W-1:0]          revision,
  output logic [BYTES_W-1:0]                  bytes,
  output logic [CHUNKS_W-1:0]                 chunks,
  output logic [shlp_pkg::HASH_W-1:0]         hash_upd
);

  logic [shlp_pkg::FIELD_IDX_W-1:0] fidx_r, fidx_nxt, fidx_upd;
  logic [63:0]                      acc_r, acc_nxt, acc_upd;
  logic [1:0]                       dcnt_r, dcnt_nxt, dcnt_upd;
  logic                             lz_r, lz_nxt, lz_upd;
  logic                             err_r, err_nxt, err_upd;
  logic [shlp_pkg::REV_W-1:0]       rev_r, rev_nxt, rev_upd;
  logic [BYTES_W-1:0]               bytes_r, bytes_nxt, bytes_upd;
  logic [CHUNKS_W-1:0]              chunks_r, chunks_nxt, chunks_upd;

  logic        is_digit;
  logic        is_newline;
  logic [3:0]  digit;
  logic [63:0] fmax;
  logic [67:0] acc_ext;
  logic [67:0] sum;

  // Classify the byte and form acc*10 + digit with headroom
  always_comb begin
    is_digit   = (text_byte >= shlp_pkg::CH_ZERO) && (text_byte <= shlp_pkg::CH_NINE);
    is_newline = (text_byte == shlp_pkg::CH_NEWLINE);
    digit      = 4'(text_byte - shlp_pkg::CH_ZERO);
    acc_ext    = {4'b0, acc_r};
    sum        = (acc_ext << 3) + (acc_ext << 1) + 68'(digit);
  end

  // Select the bound of the current field
  always_comb begin
    unique case (fidx_r)
      shlp_pkg::FLD_SCHEMA:   fmax = shlp_pkg::SCHEMA_VALUE;
      shlp_pkg::FLD_REVISION: fmax = MAX_REVISION;
      shlp_pkg::FLD_BYTES:    fmax = BYTES_MAX;
      shlp_pkg::FLD_CHUNKS:   fmax = CHUNKS_MAX;
      default:                fmax = '1;
    endcase
  end

  // Apply one byte to the field state
  always_comb begin
    fidx_upd   = fidx_r;
    acc_upd    = acc_r;
    dcnt_upd   = dcnt_r;
    lz_upd     = lz_r;
    err_upd    = err_r;
    rev_upd    = rev_r;
    bytes_upd  = bytes_r;
    chunks_upd = chunks_r;
    if (ctl.go && !err_r) begin
      if (fidx_r >= shlp_pkg::FLD_DONE) begin
        err_upd = 1'b1;
      end else if (is_digit) begin
        // Bound test: acc*10 + d must not exceed the field maximum
        if (sum > {4'b0, fmax}) begin
          err_upd = 1'b1;
        end else begin
          acc_upd = sum[63:0];
          if (dcnt_r == 2'd0) lz_upd = (digit == 4'd0);
          if (dcnt_r != shlp_pkg::DCNT_SAT) dcnt_upd = dcnt_r + 2'd1;
        end
      end else if (!is_newline) begin
        err_upd = 1'b1;
      end else if ((dcnt_r == 2'd0) || ((dcnt_r == shlp_pkg::DCNT_SAT) && lz_r)) begin
        // Empty field or leading zero
        err_upd = 1'b1;
      end else if ((fidx_r == shlp_pkg::FLD_SCHEMA) && (acc_r != shlp_pkg::SCHEMA_VALUE)) begin
        err_upd = 1'b1;
      end else begin
        case (fidx_r)
          shlp_pkg::FLD_REVISION: rev_upd    = acc_r[shlp_pkg::REV_W-1:0];
          shlp_pkg::FLD_BYTES:    bytes_upd  = acc_r[BYTES_W-1:0];
          shlp_pkg::FLD_CHUNKS:   chunks_upd = acc_r[CHUNKS_W-1:0];
          default: ;
        endcase
        fidx_upd = fidx_r + 3'd1;
        // Keep the hash value after the fifth newline
        if (fidx_r != shlp_pkg::FLD_HASH) begin
          acc_upd  = '0;
          dcnt_upd = 2'd0;
          lz_upd   = 1'b0;
        end
      end
    end
  end

  // Return to the start state after the final byte
  always_comb begin
    if (ctl.go && ctl.last) begin
      fidx_nxt   = shlp_pkg::FLD_SCHEMA;
      acc_nxt    = '0;
      dcnt_nxt   = 2'd0;
      lz_nxt     = 1'b0;
      err_nxt    = 1'b0;
      rev_nxt    = '0;
      bytes_nxt  = '0;
      chunks_nxt = '0;
    end else begin
      fidx_nxt   = fidx_upd;
      acc_nxt    = acc_upd;
      dcnt_nxt   = dcnt_upd;
      lz_nxt     = lz_upd;
      err_nxt    = err_upd;
      rev_nxt    = rev_upd;
      bytes_nxt  = bytes_upd;
      chunks_nxt = chunks_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fidx_r   <= shlp_pkg::FLD_SCHEMA;
      acc_r    <= '0;
      dcnt_r   <= 2'd0;
      lz_r     <= 1'b0;
      err_r    <= 1'b0;
      rev_r    <= '0;
      bytes_r  <= '0;
      chunks_r <= '0;
    end else begin
      fidx_r   <= fidx_nxt;
      acc_r    <= acc_nxt;
      dcnt_r   <= dcnt_nxt;
      lz_r     <= lz_nxt;
      err_r    <= err_nxt;
      rev_r    <= rev_nxt;
      bytes_r  <= bytes_nxt;
      chunks_r <= chunks_nxt;
    end
  end

  // The hash byte cannot change the saved fields, so registered copies serve
  assign sts.complete = (fidx_upd == shlp_pkg::FLD_DONE) && !err_upd;
  assign revision     = rev_r;
  assign bytes        = bytes_r;
  assign chunks       = chunks_r;
  assign hash_upd     = acc_upd;

endmodule

`default_nettype wire

// ===== src/shlp_chunk_check.sv =====
// Chunk count consistency test: chunks == ceil(bytes / CHUNK_SIZE), both nonzero.
// Depends on no package; widths come from parameters handed down by the top level.
`default_nettype none

module shlp_chunk_check #(
  parameter logic [63:0] CHUNK_SIZE = 64'd4096,
  parameter int          BYTES_W    = 20,
  parameter int          CHUNKS_W   = 9
) (
  input  wire logic                clk,
  input  wire logic [BYTES_W-1:0]  bytes,
  input  wire logic [CHUNKS_W-1:0] chunks,
  output logic                     chunk_ok
);

  localparam int              CS_W   = $clog2(CHUNK_SIZE + 64'd1);
  localparam int              PROD_W = CHUNKS_W + CS_W;
  localparam int              CMP_W  = PROD_W + 1;
  localparam logic [CS_W-1:0] CS_K   = CS_W'(CHUNK_SIZE);

  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [CMP_W-1:0]  bytes_ext;
  logic [CMP_W-1:0]  upper;
  logic [CMP_W-1:0]  prod_ext;

  // Register chunks*CHUNK_SIZE; chunks settle at least two beats before the final one
  assign prod_nxt = PROD_W'(chunks) * PROD_W'(CS_K);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // (chunks-1)*C < bytes <= chunks*C, written as bytes + C > chunks*C
  always_comb begin
    bytes_ext = CMP_W'(bytes);
    upper     = bytes_ext + CMP_W'(CHUNK_SIZE);
    prod_ext  = {1'b0, prod_r};
    chunk_ok  = (chunks != '0) && (bytes != '0) &&
                (bytes_ext <= prod_ext) && (upper > prod_ext);
  end

endmodule

`default_nettype wire

// ===== src/shlp_checker.sv =====
// Port-level assertions for the storage header parser, bound to its top level.
// Depends on shlp_pkg for payload widths and on storage_header_line_parser.
`default_nettype none

module shlp_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic                              out_status,
  input wire logic [shlp_pkg::REV_W-1:0]        out_revision,
  input wire logic [shlp_pkg::BYTES_OUT_W-1:0]  out_byte_count,
  input wire logic [shlp_pkg::CHUNKS_OUT_W-1:0] out_chunk_count,
  input wire logic [shlp_pkg::HASH_W-1:0]       out_content_hash
);

  // Stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_revision) && $stable(out_byte_count) &&
      $stable(out_chunk_count) && $stable(out_content_hash))
    else $error("result beat changed while stalled");

  // Error result carries zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> (out_revision == '0) && (out_byte_count == '0) &&
      (out_chunk_count == '0) && (out_content_hash == '0))
    else $error("error result with nonzero fields");

  // Input back-pressure only behind a stalled result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  // Reset empties the result register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind storage_header_line_parser shlp_checker u_shlp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_status       (out_chan.status),
  .out_revision     (out_chan.revision),
  .out_byte_count   (out_chan.byte_count),
  .out_chunk_count  (out_chan.chunk_count),
  .out_content_hash (out_chan.content_hash)
);

`default_nettype wire

// ===== tb/shlp_checker.sv =====
// Checker for the storage header parser: watches the byte and result channels,
// predicts each result from the accepted bytes and compares it field by field.
// Depends on shlp_pkg and the channel interfaces in shlp_if.
`default_nettype none

module shlp_scoreboard (
  input  wire logic clk,
  input  wire logic rst_n,
  shlp_in_if        in_mon,
  shlp_out_if       out_mon,
  output int        fail_count,
  output int        pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import shlp_pkg::*;

  typedef struct packed {
    logic                    status;
    logic [REV_W-1:0]        revision;
    logic [BYTES_OUT_W-1:0]  byte_count;
    logic [CHUNKS_OUT_W-1:0] chunk_count;
    logic [HASH_W-1:0]       content_hash;
  } header_result_t;

  // Results owed by the parser, oldest first
  header_result_t header_results_q[$];

  // Mirror of the parser state
  logic [FIELD_IDX_W-1:0] cur_field;
  logic [63:0]            field_value;
  logic [1:0]             digit_seen;
  logic                   first_zero;
  logic                   parse_error;
  logic [63:0]            kept_revision;
  logic [63:0]            kept_bytes;
  logic [63:0]            kept_chunks;

  function automatic logic [63:0] field_limit(logic [FIELD_IDX_W-1:0] f);
    case (f)
      FLD_SCHEMA:   return SCHEMA_VALUE;
      FLD_REVISION: return MAX_REVISION_DEF;
      FLD_BYTES:    return WIRE_CAPACITY_DEF - 64'd1;
      FLD_CHUNKS:   return WIRE_CAPACITY_DEF / CHUNK_SIZE_DEF + 64'd1;
      default:      return '1;
    endcase
  endfunction

  // Start a new field: drop the digits gathered so far
  function automatic void clear_digits();
    field_value = '0;
    digit_seen  = '0;
    first_zero  = 1'b0;
  endfunction

  function automatic void restart_header();
    cur_field     = FLD_SCHEMA;
    clear_digits();
    parse_error   = 1'b0;
    kept_revision = '0;
    kept_bytes    = '0;
    kept_chunks   = '0;
  endfunction

  // Advance the parser by one header character
  function automatic void take_char(logic [BYTE_W-1:0] ch);
    logic [63:0] digit;
    logic [63:0] limit;
    if (parse_error) return;
    if (cur_field >= FLD_DONE) begin
      parse_error = 1'b1;
      return;
    end
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      digit = 64'(ch) - 64'(CH_ZERO);
      limit = field_limit(cur_field);
      // overflow is judged before the digit is folded in
      if (digit > limit || field_value > (limit - digit) / 64'd10) begin
        parse_error = 1'b1;
        return;
      end
      if (digit_seen == '0) first_zero = (digit == '0);
      field_value = field_value * 64'd10 + digit;
      if (digit_seen < DCNT_SAT) digit_seen++;
      return;
    end
    if (ch != CH_NEWLINE) begin
      parse_error = 1'b1;
      return;
    end
    // empty field or a leading zero ahead of more digits
    if (digit_seen == '0 || (digit_seen == DCNT_SAT && first_zero)) begin
      parse_error = 1'b1;
      return;
    end
    case (cur_field)
      FLD_SCHEMA: begin
        if (field_value != SCHEMA_VALUE) begin
          parse_error = 1'b1;
          return;
        end
      end
      FLD_REVISION: kept_revision = field_value;
      FLD_BYTES:    kept_bytes    = field_value;
      FLD_CHUNKS:   kept_chunks   = field_value;
      default: ;
    endcase
    cur_field++;
    // the hash stays in field_value once the last newline is seen
    if (cur_field < FLD_DONE) clear_digits();
  endfunction

  function automatic header_result_t header_verdict();
    header_result_t res;
    logic           good;
    good = !parse_error && cur_field == FLD_DONE && kept_bytes != '0 &&
           kept_chunks != '0 &&
           kept_chunks == (kept_bytes + CHUNK_SIZE_DEF - 64'd1) / CHUNK_SIZE_DEF;
    res = '0;
    if (good) begin
      res.revision     = kept_revision[REV_W-1:0];
      res.byte_count   = kept_bytes[BYTES_OUT_W-1:0];
      res.chunk_count  = kept_chunks[CHUNKS_OUT_W-1:0];
      res.content_hash = field_value;
    end else begin
      res.status = 1'b1;
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t shlp_scoreboard: %s mismatch expected %0h actual %0h",
               $time, name, want, got);
    end
  endfunction

  // Predict on each accepted byte beat, compare on each accepted result beat
  always @(posedge clk) begin : watch
    header_result_t got;
    header_result_t want;
    if (!rst_n) begin
      restart_header();
      header_results_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        take_char(in_mon.text_byte);
        if (in_mon.final_byte) begin
          header_results_q.push_back(header_verdict());
          restart_header();
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{status:       out_mon.status,
                revision:     out_mon.revision,
                byte_count:   out_mon.byte_count,
                chunk_count:  out_mon.chunk_count,
                content_hash: out_mon.content_hash};
        if (header_results_q.size() == 0) begin
          fail_count++;
          $display("%0t shlp_scoreboard: unexpected result expected none actual %0h",
                   $time, got);
        end else begin
          want = header_results_q.pop_front();
          check_field("status", 64'(want.status), 64'(got.status));
          check_field("revision", 64'(want.revision), 64'(got.revision));
          check_field("byte_count", 64'(want.byte_count), 64'(got.byte_count));
          check_field("chunk_count", 64'(want.chunk_count), 64'(got.chunk_count));
          check_field("content_hash", want.content_hash, got.content_hash);
        end
      end
    end
    pending_count <= header_results_q.size();
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Top of the storage header parser testbench: clock, reset, header text stimulus,
// result-side back-pressure and the verdict. Depends on shlp_pkg, shlp_if,
// storage_header_line_parser and shlp_scoreboard.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import shlp_pkg::*;

  localparam int HOLD_CYCLES = 300;

  typedef enum int {
    HK_VALID, HK_CHUNKS, HK_LEAD_ZERO, HK_OVERFLOW, HK_EMPTY,
    HK_JUNK, HK_TRAILING, HK_TRUNCATED, HK_NOISE
  } header_kind_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  shlp_in_if  in_chan ();
  shlp_out_if out_chan ();

  int fail_count;
  int pending_count;

  int          n_items  = 0;
  int          n_finals = 0;
  bit          calm     = 1'b0;
  bit          hold_req = 1'b0;
  logic [7:0]  hdr_q[$];

  storage_header_line_parser u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  shlp_scoreboard u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #5 clk = ~clk;

  initial begin
    #3000000;
    $display("tb: FAIL");
    $finish;
  end

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) hdr_q.push_back(s[i]);
  endfunction

  // Build one header of the given kind into hdr_q
  function automatic void build_header(header_kind_t kind);
    string       f[5];
    logic [63:0] rev;
    logic [63:0] nb;
    logic [63:0] nc;
    logic [63:0] hv;
    int          idx;
    int          pos;
    int          keep;
    logic [7:0]  junk;
    case ($urandom_range(0, 5))
      0:       rev = '0;
      1:       rev = MAX_REVISION_DEF;
      2:       rev = 64'($urandom_range(0, 32'(MAX_REVISION_DEF)));
      default: rev = 64'($urandom_range(1, 999));
    endcase
    case ($urandom_range(0, 6))
      0:       nb = 64'd1;
      1:       nb = WIRE_CAPACITY_DEF - 64'd1;
      2:       nb = CHUNK_SIZE_DEF;
      3:       nb = CHUNK_SIZE_DEF + 64'd1;
      4:       nb = 64'($urandom_range(1, 32'(WIRE_CAPACITY_DEF - 64'd1)));
      default: nb = 64'($urandom_range(1, 9999));
    endcase
    nc = (nb + CHUNK_SIZE_DEF - 64'd1) / CHUNK_SIZE_DEF;
    case ($urandom_range(0, 4))
      0:       hv = '0;
      1:       hv = '1;
      2, 3:    hv = {$urandom, $urandom};
      default: hv = 64'($urandom_range(0, 99999));
    endcase
    // break the chunk rule
    if (kind == HK_CHUNKS) begin
      case ($urandom_range(0, 3))
        0: nc = nc + 64'd1;
        1: nc = nc - 64'd1;
        2: begin
          nb = '0;
          nc = '0;
        end
        default: begin
          nb = WIRE_CAPACITY_DEF - 64'd1;
          nc = WIRE_CAPACITY_DEF / CHUNK_SIZE_DEF + 64'd1;
        end
      endcase
    end
    f[0] = "1";
    f[1] = $sformatf("%0d", rev);
    f[2] = $sformatf("%0d", nb);
    f[3] = $sformatf("%0d", nc);
    f[4] = $sformatf("%0d", hv);
    idx  = $urandom_range(0, 4);
    case (kind)
      HK_LEAD_ZERO: f[idx] = {"0", f[idx]};
      HK_OVERFLOW: begin
        case (idx)
          0: f[0] = $urandom_range(0, 1) ? "2" : "0";
          1: f[1] = "1048576";
          2: f[2] = $urandom_range(0, 1) ? "1048576" : "99999999";
          3: f[3] = "258";
          default: f[4] = $urandom_range(0, 1) ? "18446744073709551616"
                                               : "99999999999999999999999";
        endcase
      end
      HK_EMPTY: f[idx] = "";
      default: ;
    endcase
    hdr_q.delete();
    for (int i = 0; i < 5; i++) push_text({f[i], "\n"});
    case (kind)
      HK_JUNK: begin
        pos = $urandom_range(0, hdr_q.size() - 1);
        if ($urandom_range(0, 1)) begin
          do junk = 8'($urandom_range(0, 255));
          while ((junk >= CH_ZERO && junk <= CH_NINE) || junk == CH_NEWLINE);
          hdr_q.insert(pos, junk);
        end else begin
          hdr_q[pos] = 8'($urandom_range(0, 255));
        end
      end
      HK_TRAILING: repeat ($urandom_range(1, 3)) hdr_q.push_back(8'($urandom_range(0, 255)));
      HK_TRUNCATED: begin
        keep = $urandom_range(1, hdr_q.size() - 1);
        while (hdr_q.size() > keep) void'(hdr_q.pop_back());
      end
      HK_NOISE: begin
        hdr_q.delete();
        repeat ($urandom_range(1, 6)) hdr_q.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
  endfunction

  // Offer hdr_q beat by beat, final flag on the last byte
  task automatic send_header();
    for (int i = 0; i < hdr_q.size(); i++) begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        in_chan.valid = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      in_chan.valid      = 1'b1;
      in_chan.text_byte  = hdr_q[i];
      in_chan.final_byte = (i == hdr_q.size() - 1);
      @(posedge clk);
      while (!in_chan.ready) @(posedge clk);
      n_items++;
      @(negedge clk);
    end
    n_finals++;
  endtask

  task automatic wait_drained();
    in_chan.valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    bit hold_taken;
    hold_taken     = 1'b0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken     = 1'b1;
        out_chan.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_chan.ready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end else begin
        out_chan.ready = 1'b1;
      end
    end
  end

  // Header text stimulus
  initial begin
    bit           hold_done;
    int           r;
    header_kind_t kind;
    hold_done          = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.text_byte  = '0;
    in_chan.final_byte = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // smallest legal header, lone final bytes, then a header cut after the schema field
    hdr_q.delete();
    push_text("1\n0\n1\n1\n0\n");
    send_header();
    hdr_q = {8'h00};
    send_header();
    hdr_q = {CH_NEWLINE};
    send_header();
    hdr_q = {8'hff};
    send_header();
    hdr_q.delete();
    push_text("1\n");
    send_header();
    wait_drained();

    while (n_items < 1750 || n_finals < 60) begin
      calm = (n_items >= 1500);
      // stall the result side and offer twelve lone final bytes so that the input backs up
      if (!hold_done && n_items >= 500) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
        repeat (12) begin
          hdr_q = {8'($urandom_range(0, 255))};
          send_header();
        end
        wait_drained();
      end
      if (!calm && $urandom_range(0, 9) == 0) wait_drained();
      r = $urandom_range(0, 15);
      case (r)
        7:       kind = HK_CHUNKS;
        8:       kind = HK_LEAD_ZERO;
        9:       kind = HK_OVERFLOW;
        10:      kind = HK_EMPTY;
        11:      kind = HK_JUNK;
        12:      kind = HK_TRAILING;
        13:      kind = HK_TRUNCATED;
        14, 15:  kind = HK_NOISE;
        default: kind = HK_VALID;
      endcase
      build_header(kind);
      send_header();
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
